// ----- rtl/ocsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocsm_pkg
// Shared types and constants of the object cache slot manager.
// ----------------------------------------------------------------------------
package ocsm_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W    = 14;
  localparam int SLOT_W   = 4;

  localparam logic [AGE_W-1:0] TOP_AGE = AGE_W'(9999);

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] key;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } out_t;

  // One entry as seen at the store's read port.
  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] tag;
    logic [AGE_W-1:0]    age;
  } entry_t;

  // Insert write from the sequencer to the store.
  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    idx;
    logic [KEY_BITS-1:0] tag;
  } wr_t;

  // Verdict of the shared compare unit for one entry.
  typedef struct packed {
    logic match;
    logic empty;
    logic younger;
  } scan_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    to_slot = SLOT_W'(idx);
  endfunction

endpackage

// ----- rtl/ocsm_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_cache_slot_manager_top
// Fully associative tag store of a small object cache, FIFO replacement.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high while busy is low; busy then
// stays high until its result is out. A lookup walks the entries one per
// cycle through a single compare unit and stops at the first valid match;
// the result is strobed on out_valid for one cycle right after the last
// entry visited. An insert walks the entries the same way to find its
// victim (the first empty entry ends the walk early, otherwise all ENTRIES (16)
// are visited for the lowest age) and then writes the tag store in a write
// state, after which its result is strobed the same way. busy
// drops in the cycle the result is shown, so a new transaction can start
// there. There is no backpressure on the result side: out_valid is a
// one-cycle strobe and the receiver must take it.
// ----------------------------------------------------------------------------
module object_cache_slot_manager_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ocsm_pkg::in_t  in_req,
  output logic           out_valid,
  output ocsm_pkg::out_t out_rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t                          state_r,   state_nxt;
  logic                            cmd_r,     cmd_nxt;
  logic [ocsm_pkg::KEY_BITS-1:0]   key_r,     key_nxt;
  logic [ocsm_pkg::IDX_W-1:0]      idx_r,     idx_nxt;
  logic [ocsm_pkg::IDX_W-1:0]      best_r,    best_nxt;
  logic [ocsm_pkg::AGE_W-1:0]      min_age_r, min_age_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ocsm_pkg::out_t                  out_rsp_r, out_rsp_nxt;

  ocsm_pkg::entry_t                rd_entry;
  ocsm_pkg::scan_t                 verdict;
  ocsm_pkg::wr_t                   wr;
  logic                            last_idx;

  // Tag store and the shared compare unit.
  ocsm_entry_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  ocsm_scan_unit u_scan (
    .entry   (rd_entry),
    .key     (key_r),
    .min_age (min_age_r),
    .verdict (verdict)
  );

  assign last_idx = (idx_r == ocsm_pkg::IDX_W'(ocsm_pkg::ENTRIES - 1));

  // Store write happens in the write state, at the victim found by the scan.
  assign wr.we  = (state_r == ST_WRITE);
  assign wr.idx = best_r;
  assign wr.tag = key_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    min_age_nxt   = min_age_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt     = in_req.cmd;
          key_nxt     = in_req.key[ocsm_pkg::KEY_BITS-1:0];
          idx_nxt     = '0;
          best_nxt    = '0;
          // victim search starts at top age, default entry 0
          min_age_nxt = ocsm_pkg::TOP_AGE;
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (cmd_r == ocsm_pkg::CMD_LOOKUP) begin
          if (verdict.match) begin
            out_valid_nxt    = 1'b1;
            out_rsp_nxt.hit  = 1'b1;
            out_rsp_nxt.slot = ocsm_pkg::to_slot(idx_r);
            state_nxt        = ST_IDLE;
          end else if (last_idx) begin
            out_valid_nxt    = 1'b1;
            out_rsp_nxt.hit  = 1'b0;
            out_rsp_nxt.slot = '0;
            state_nxt        = ST_IDLE;
          end else begin
            idx_nxt = idx_r + ocsm_pkg::IDX_W'(1);
          end
        end else begin
          if (verdict.empty) begin
            // first empty entry wins outright
            best_nxt  = idx_r;
            state_nxt = ST_WRITE;
          end else begin
            if (verdict.younger) begin
              best_nxt    = idx_r;
              min_age_nxt = rd_entry.age;
            end
            if (last_idx) begin
              state_nxt = ST_WRITE;
            end else begin
              idx_nxt = idx_r + ocsm_pkg::IDX_W'(1);
            end
          end
        end
      end

      ST_WRITE: begin
        out_valid_nxt    = 1'b1;
        out_rsp_nxt.hit  = 1'b0;
        out_rsp_nxt.slot = ocsm_pkg::to_slot(best_r);
        state_nxt        = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
      key_r       <= key_nxt;
      idx_r       <= idx_nxt;
      best_r      <= best_nxt;
      min_age_r   <= min_age_nxt;
      out_rsp_r   <= out_rsp_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // a result only follows a cycle of work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != ST_IDLE))
    else $error("result strobe without a transaction in flight");

  // an insert never reports a hit
  a_insert_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.hit) |-> $past(cmd_r == ocsm_pkg::CMD_LOOKUP))
    else $error("hit reported for an insert");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // the store is written only at the end of an insert scan
  a_write_after_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (cmd_r == ocsm_pkg::CMD_INSERT && $past(state_r == ST_SCAN)))
    else $error("store write outside an insert");

endmodule

// ----- rtl/ocsm_entry_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocsm_entry_store
// Valid bits, tags and ages of all entries; one read port, insert update.
// ----------------------------------------------------------------------------
module ocsm_entry_store (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ocsm_pkg::IDX_W-1:0] rd_idx,
  output ocsm_pkg::entry_t        rd_entry,
  input  ocsm_pkg::wr_t           wr
);

  logic                            valid_r [ocsm_pkg::ENTRIES];
  logic [ocsm_pkg::KEY_BITS-1:0]   tag_r   [ocsm_pkg::ENTRIES];
  logic [ocsm_pkg::AGE_W-1:0]      age_r   [ocsm_pkg::ENTRIES];
  logic [ocsm_pkg::AGE_W-1:0]      age_nxt [ocsm_pkg::ENTRIES];

  assign rd_entry.valid = valid_r[rd_idx];
  assign rd_entry.tag   = tag_r[rd_idx];
  assign rd_entry.age   = age_r[rd_idx];

  // written entry goes to top age, every other valid entry ages by one (floor 0)
  always_comb begin
    for (int i = 0; i < ocsm_pkg::ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
      if (wr.we) begin
        if (wr.idx == ocsm_pkg::IDX_W'(i)) begin
          age_nxt[i] = ocsm_pkg::TOP_AGE;
        end else if (valid_r[i] && (age_r[i] != '0)) begin
          age_nxt[i] = age_r[i] - ocsm_pkg::AGE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ocsm_pkg::ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        age_r[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < ocsm_pkg::ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
      if (wr.we) begin
        valid_r[wr.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      tag_r[wr.idx] <= wr.tag;
    end
  end

endmodule

// ----- rtl/ocsm_scan_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocsm_scan_unit
// Shared compare unit: tag match and age compare for the entry under scan.
// ----------------------------------------------------------------------------
module ocsm_scan_unit (
  input  ocsm_pkg::entry_t              entry,
  input  logic [ocsm_pkg::KEY_BITS-1:0] key,
  input  logic [ocsm_pkg::AGE_W-1:0]    min_age,
  output ocsm_pkg::scan_t               verdict
);

  assign verdict.match   = entry.valid && (entry.tag == key);
  assign verdict.empty   = !entry.valid;
  assign verdict.younger = entry.valid && (entry.age < min_age);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the object cache slot manager: directed and random
// lookups and inserts against a cycle-free predictor of the tag store.
// ----------------------------------------------------------------------------
// A driver on the falling edge presents queued requests in bursts with random
// gaps. A monitor on the rising edge takes each accepted transaction through
// the predictor and checks every strobed result against the oldest expected
// response. A watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT  = 2000;   // cycles with no transaction on either side
  localparam int RANDOM_ITEMS = 1600;
  localparam int POOL_SIZE    = 24;

  logic           clk   = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  ocsm_pkg::in_t  in_req = '0;
  logic           busy;
  logic           out_valid;
  ocsm_pkg::out_t out_rsp;

  object_cache_slot_manager_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predicted tag store: valid bits, tags and insertion ages
  // --------------------------------------------------------------------------
  logic                          model_valid [ocsm_pkg::ENTRIES];
  logic [ocsm_pkg::KEY_BITS-1:0] model_tag   [ocsm_pkg::ENTRIES];
  logic [ocsm_pkg::AGE_W-1:0]    model_age   [ocsm_pkg::ENTRIES];

  ocsm_pkg::in_t  pending_reqs  [$];   // requests not yet taken by the block
  ocsm_pkg::out_t expected_rsps [$];   // responses owed by the block, oldest first

  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  logic took           = 1'b0;   // a transaction was accepted at the last edge

  // Lookup: first valid match wins. Insert: first empty entry, else the
  // oldest (lowest age, lower index on a tie); the new entry gets the top
  // age and every other valid entry ages by one, never below zero.
  function automatic ocsm_pkg::out_t tag_store_predict(ocsm_pkg::in_t req);
    ocsm_pkg::out_t                rsp;
    logic [ocsm_pkg::KEY_BITS-1:0] key;
    logic [ocsm_pkg::AGE_W-1:0]    min_age;
    int                            victim;
    bit                            found;
    rsp   = '0;
    key   = req.key[ocsm_pkg::KEY_BITS-1:0];
    found = 1'b0;
    if (req.cmd == ocsm_pkg::CMD_LOOKUP) begin
      for (int i = 0; i < ocsm_pkg::ENTRIES; i++) begin
        if (!found && model_valid[i] && model_tag[i] == key) begin
          found    = 1'b1;
          rsp.hit  = 1'b1;
          rsp.slot = ocsm_pkg::SLOT_W'(i);
        end
      end
    end else begin
      victim = -1;
      for (int i = 0; i < ocsm_pkg::ENTRIES; i++) begin
        if (victim < 0 && !model_valid[i]) victim = i;
      end
      if (victim < 0) begin
        // all full: nobody below top age leaves entry 0 as the victim
        victim  = 0;
        min_age = ocsm_pkg::TOP_AGE;
        for (int i = 0; i < ocsm_pkg::ENTRIES; i++) begin
          if (model_age[i] < min_age) begin
            min_age = model_age[i];
            victim  = i;
          end
        end
      end
      model_valid[victim] = 1'b1;
      model_tag[victim]   = key;
      model_age[victim]   = ocsm_pkg::TOP_AGE;
      for (int i = 0; i < ocsm_pkg::ENTRIES; i++) begin
        if (i != victim && model_valid[i] && model_age[i] != '0)
          model_age[i] = model_age[i] - 1'b1;
      end
      rsp.slot = ocsm_pkg::SLOT_W'(victim);
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH @%0t: %0s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Driver: falling edge, bursts of requests with random gaps between them
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          // about a third of the bursts follow back to back
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        start  <= 1'b1;
        in_req <= pending_reqs[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: rising edge; check results first, then predict the new request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ocsm_pkg::out_t want;
    if (rst_n) begin
      took = start && !busy;
      if (out_valid) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("unexpected result hit=%0b slot=%0d",
                                    out_rsp.hit, out_rsp.slot));
        end else begin
          want = expected_rsps.pop_front();
          if (out_rsp.hit !== want.hit)
            report_mismatch($sformatf("hit got %0b want %0b", out_rsp.hit, want.hit));
          if (out_rsp.slot !== want.slot)
            report_mismatch($sformatf("slot got %0d want %0d", out_rsp.slot, want.slot));
        end
      end
      if (took)
        expected_rsps.push_back(tag_store_predict(pending_reqs.pop_front()));
      if (took || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb failed");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  logic [63:0] key_pool [POOL_SIZE];

  task automatic queue_req(logic cmd, logic [63:0] key);
    ocsm_pkg::in_t req;
    req.cmd = cmd;
    req.key = key;
    pending_reqs.push_back(req);
  endtask

  initial begin
    logic [63:0] key;
    for (int i = 0; i < ocsm_pkg::ENTRIES; i++) begin
      model_valid[i] = 1'b0;
      model_tag[i]   = '0;
      model_age[i]   = '0;
    end

    // Directed: empty store, key extremes, duplicate insert, fill, eviction.
    queue_req(ocsm_pkg::CMD_LOOKUP, 64'h0);                    // miss on an empty store
    queue_req(ocsm_pkg::CMD_INSERT, 64'h0);                    // -> entry 0
    queue_req(ocsm_pkg::CMD_INSERT, '1);                       // -> entry 1
    queue_req(ocsm_pkg::CMD_LOOKUP, '1);
    queue_req(ocsm_pkg::CMD_LOOKUP, 64'h0);
    queue_req(ocsm_pkg::CMD_INSERT, '1);                       // duplicate tag -> entry 2
    queue_req(ocsm_pkg::CMD_LOOKUP, '1);                       // lowest copy wins
    queue_req(ocsm_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000);  // miss, top bit only
    for (int k = 3; k < ocsm_pkg::ENTRIES; k++)
      queue_req(ocsm_pkg::CMD_INSERT, 64'h1 << (4 * k + 1));   // fill the rest
    queue_req(ocsm_pkg::CMD_INSERT, 64'hA5A5_5A5A_F00F_0FF0);  // full: evicts the oldest
    queue_req(ocsm_pkg::CMD_LOOKUP, 64'h0);                    // evicted, now a miss
    queue_req(ocsm_pkg::CMD_LOOKUP, '1);                       // older copy still present
    queue_req(ocsm_pkg::CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFE);  // evicts the next oldest

    // Pool: half fully random, half one bit away from a base key so that
    // near misses exercise the full-width compare.
    for (int p = 0; p < POOL_SIZE; p++) begin
      if (p < POOL_SIZE / 2 || p == 0)
        key_pool[p] = {$urandom, $urandom};
      else
        key_pool[p] = key_pool[0] ^ (64'h1 << $urandom_range(0, 63));
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 7)
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        key = {$urandom, $urandom};
      queue_req($urandom_range(0, 1) ? ocsm_pkg::CMD_INSERT : ocsm_pkg::CMD_LOOKUP, key);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
      @(posedge clk);
    // longest insert scans every entry and then passes through the write state
    repeat (ocsm_pkg::ENTRIES + 4) @(posedge clk);

    if (mismatch_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ----- object_cache_slot_manager_top.f -----
rtl/ocsm_pkg.sv
rtl/ocsm_entry_store.sv
rtl/ocsm_scan_unit.sv
rtl/ocsm_top.sv
tb/sv/tb.sv
